// ===== hdl/glms_pkg.sv =====
package glms_pkg;

  localparam logic [7:0] NONE_CODE = 8'hFF;

  // item kinds carried on in_tuser
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // load phase codes
  localparam logic [1:0] PHASE_UNKNOWN = 2'd0;
  localparam logic [1:0] PHASE_STANCE  = 2'd1;
  localparam logic [1:0] PHASE_NOLOAD  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_AUTO_ENABLE = 3'd0;
  localparam logic [2:0] REG_MAP_LABELS  = 3'd1;
  localparam logic [2:0] REG_MAP_STATES  = 3'd2;
  localparam logic [2:0] REG_MAP_COUNT   = 3'd3;
  localparam logic [2:0] REG_THRESHOLD   = 3'd4;
  localparam logic [2:0] REG_WINDOW      = 3'd5;

  localparam logic [63:0] MAP_LABELS_RST = 64'h0000_0504_0302_0100;
  localparam logic [63:0] MAP_STATES_RST = 64'h0000_0402_0300_0101;
  localparam logic [3:0]  MAP_COUNT_RST  = 4'd6;
  localparam logic [6:0]  THRESHOLD_RST  = 7'd80;
  localparam logic [15:0] WINDOW_RST     = 16'd400;

  typedef struct packed {
    logic [63:0] map_labels;
    logic [63:0] map_states;
    logic [3:0]  map_count;
    logic [15:0] window_ms;
  } glms_map_cfg_t;

endpackage

// ===== hdl/glms_history.sv =====
module glms_history #(
  parameter int HISTORY_DEPTH = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] label,
  input  logic [6:0] confidence,
  input  logic [6:0] threshold,
  output logic [7:0] stable_nxt
);
  import glms_pkg::*;

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);

  logic [7:0]        hist_lab_r  [HISTORY_DEPTH];
  logic [6:0]        hist_conf_r [HISTORY_DEPTH];
  logic [7:0]        lab_view    [HISTORY_DEPTH];
  logic [6:0]        conf_view   [HISTORY_DEPTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [7:0]        stable_r;
  logic              same, sure;

  always_comb begin
    slot_nxt = (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    fill_nxt = (fill_r == CNT_W'(HISTORY_DEPTH)) ? fill_r : fill_r + 1'b1;
    same = 1'b1;
    sure = 1'b1;
    // ring contents as they stand after this write
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      lab_view[j]  = (slot_r == SLOT_W'(j)) ? label      : hist_lab_r[j];
      conf_view[j] = (slot_r == SLOT_W'(j)) ? confidence : hist_conf_r[j];
    end
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      if (lab_view[j] != lab_view[0]) same = 1'b0;
      if (conf_view[j] < threshold) sure = 1'b0;
    end
    stable_nxt = stable_r;
    if (take && fill_nxt == CNT_W'(HISTORY_DEPTH) && same && sure) stable_nxt = lab_view[0];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        hist_lab_r[j]  <= lab_view[j];
        hist_conf_r[j] <= conf_view[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      stable_r <= NONE_CODE;
    end else if (take) begin
      slot_r   <= slot_nxt;
      fill_r   <= fill_nxt;
      stable_r <= stable_nxt;
    end
  end

endmodule

// ===== hdl/glms_sched.sv =====
module glms_sched #(
  parameter int MAP_ENTRIES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tick,
  input  logic                   stance,
  input  logic [31:0]            now_ms,
  input  logic [7:0]             stable,
  input  glms_pkg::glms_map_cfg_t cfg,
  output logic [7:0]             apply_state
);
  import glms_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] start_r, start_nxt;
  logic [7:0]  applied_r, applied_nxt;
  logic [7:0]  pend_lab_r, pend_lab_nxt;
  logic [7:0]  pend_st_r, pend_st_nxt;
  logic        entered;
  logic [3:0]  count_sat;
  logic [7:0]  want;
  logic [7:0]  apply;
  logic [31:0] elapsed;

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    entered   = 1'b0;
    unique case (phase_r)
      PHASE_UNKNOWN: if (stance) phase_nxt = PHASE_STANCE;
      PHASE_STANCE: begin
        if (!stance) begin
          phase_nxt = PHASE_NOLOAD;
          start_nxt = now_ms;
          entered   = 1'b1;
        end
      end
      PHASE_NOLOAD: if (stance) phase_nxt = PHASE_STANCE;
      default:      if (stance) phase_nxt = PHASE_STANCE;
    endcase
  end

  // first matching entry wins, so scan from the top down
  always_comb begin
    count_sat = (cfg.map_count > 4'(MAP_ENTRIES)) ? 4'(MAP_ENTRIES) : cfg.map_count;
    want = NONE_CODE;
    for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
      if (4'(i) < count_sat && cfg.map_labels[8*i +: 8] == stable)
        want = cfg.map_states[8*i +: 8];
    end
  end

  always_comb begin
    applied_nxt  = applied_r;
    pend_lab_nxt = pend_lab_r;
    pend_st_nxt  = pend_st_r;
    apply        = NONE_CODE;
    elapsed      = now_ms - start_nxt;
    if (stable != NONE_CODE && want != NONE_CODE) begin
      if (stable == applied_r) begin
        if (entered && pend_lab_r != NONE_CODE && pend_lab_r == stable) begin
          apply        = pend_st_r;
          applied_nxt  = stable;
          pend_lab_nxt = NONE_CODE;
          pend_st_nxt  = NONE_CODE;
        end
      end else if (phase_nxt == PHASE_NOLOAD &&
                   (entered || elapsed <= {16'd0, cfg.window_ms})) begin
        apply        = want;
        applied_nxt  = stable;
        pend_lab_nxt = NONE_CODE;
        pend_st_nxt  = NONE_CODE;
      end else begin
        // defer until the next no-load entry
        pend_lab_nxt = stable;
        pend_st_nxt  = want;
      end
    end
  end

  assign apply_state = tick ? apply : NONE_CODE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PHASE_UNKNOWN;
      start_r    <= '0;
      applied_r  <= NONE_CODE;
      pend_lab_r <= NONE_CODE;
      pend_st_r  <= NONE_CODE;
    end else if (tick) begin
      phase_r    <= phase_nxt;
      start_r    <= start_nxt;
      applied_r  <= applied_nxt;
      pend_lab_r <= pend_lab_nxt;
      pend_st_r  <= pend_st_nxt;
    end
  end

endmodule

// ===== hdl/gait_label_motor_state_scheduler.sv =====
// Gait label to motor state scheduler. Takes one item per clock: an input
// register, combinational compare logic that also updates the ring and the
// no-load detector, and an output register, so a result passes both
// registers before it shows on out_tvalid, and the block sustains one
// transaction per cycle as long as out_tready stays high. in_tuser selects
// prediction (0) or control tick (1). Every accepted item gives exactly one
// result. Configuration writes are taken at any edge with cfg_we high and
// should only be made while no item is in flight.
module gait_label_motor_state_scheduler #(
  parameter int HISTORY_DEPTH = 3,
  parameter int MAP_ENTRIES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // label[7:0], confidence[14:8], in_stance[15], now_ms[47:16]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // stable_label[7:0], apply_valid[8], motor_state[16:9], zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import glms_pkg::*;

  logic          auto_r;
  logic [6:0]    thr_r;
  glms_map_cfg_t map_cfg_r;

  logic          s1_valid_r;
  logic          s1_cmd_r;
  logic [47:0]   s1_data_r;
  logic          out_valid_r;
  logic [23:0]   out_data_r;
  logic [23:0]   out_data_nxt;
  logic          out_load;
  logic          take, tick;
  logic [7:0]    stable_nxt;
  logic [7:0]    motor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r               <= 1'b0;
      thr_r                <= THRESHOLD_RST;
      map_cfg_r.map_labels <= MAP_LABELS_RST;
      map_cfg_r.map_states <= MAP_STATES_RST;
      map_cfg_r.map_count  <= MAP_COUNT_RST;
      map_cfg_r.window_ms  <= WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUTO_ENABLE: auto_r               <= cfg_wdata[0];
        REG_MAP_LABELS:  map_cfg_r.map_labels <= cfg_wdata;
        REG_MAP_STATES:  map_cfg_r.map_states <= cfg_wdata;
        REG_MAP_COUNT:   map_cfg_r.map_count  <= cfg_wdata[3:0];
        REG_THRESHOLD:   thr_r                <= cfg_wdata[6:0];
        REG_WINDOW:      map_cfg_r.window_ms  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign take      = out_load && s1_cmd_r == CMD_PREDICT;
  assign tick      = out_load && s1_cmd_r == CMD_TICK && auto_r;

  glms_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_history (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .label      (s1_data_r[7:0]),
    .confidence (s1_data_r[14:8]),
    .threshold  (thr_r),
    .stable_nxt (stable_nxt)
  );

  glms_sched #(.MAP_ENTRIES(MAP_ENTRIES)) u_sched (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .stance      (s1_data_r[15]),
    .now_ms      (s1_data_r[47:16]),
    .stable      (stable_nxt),
    .cfg         (map_cfg_r),
    .apply_state (motor)
  );

  assign out_data_nxt = {7'd0, motor, motor != NONE_CODE, stable_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) s1_valid_r <= 1'b1;
      else if (out_load)          s1_valid_r <= 1'b0;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata;
    end
    if (out_load) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/glms_checker.sv =====
module glms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  import glms_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the apply flag agrees with the motor state field
  a_apply_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8] == (out_tdata[16:9] != NONE_CODE))
    else $error("apply flag and motor state disagree");

  // nothing is applied without a stable label
  a_apply_needs_label: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7:0] != NONE_CODE)
    else $error("motor state applied with no stable label");

  // reset empties the output stage
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // padding stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0)
    else $error("nonzero padding in result");

endmodule

bind gait_label_motor_state_scheduler glms_checker u_glms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
